[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is low.
`define SIA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Condition that must never be seen.
`define SIA_NEVER(label, clk, rst_n, expr) \
    `SIA_ASSERT(label, clk, rst_n, !(expr))

`endif

[rtl/sia_pkg.sv]
// Types, opcodes and status codes of the script integer ALU.
package sia_pkg;

    localparam int DW      = 32;
    localparam int SHW     = $clog2(DW);
    // Delay constant used by the checker and the testbench.
    localparam int LATENCY = DW + 3;

    localparam logic [5:0] OP_COMMA = 6'd0;
    localparam logic [5:0] OP_ADD   = 6'd1;
    localparam logic [5:0] OP_ADDA  = 6'd2;
    localparam logic [5:0] OP_SUB   = 6'd3;
    localparam logic [5:0] OP_SUBA  = 6'd4;
    localparam logic [5:0] OP_MUL   = 6'd5;
    localparam logic [5:0] OP_MULA  = 6'd6;
    localparam logic [5:0] OP_DIV   = 6'd7;
    localparam logic [5:0] OP_DIVA  = 6'd8;
    localparam logic [5:0] OP_MOD   = 6'd9;
    localparam logic [5:0] OP_MODA  = 6'd10;
    localparam logic [5:0] OP_AND   = 6'd11;
    localparam logic [5:0] OP_ANDA  = 6'd12;
    localparam logic [5:0] OP_OR    = 6'd13;
    localparam logic [5:0] OP_ORA   = 6'd14;
    localparam logic [5:0] OP_XOR   = 6'd15;
    localparam logic [5:0] OP_XORA  = 6'd16;
    localparam logic [5:0] OP_SHL   = 6'd17;
    localparam logic [5:0] OP_SHLA  = 6'd18;
    localparam logic [5:0] OP_SAR   = 6'd19;
    localparam logic [5:0] OP_SARA  = 6'd20;
    localparam logic [5:0] OP_SHR   = 6'd21;
    localparam logic [5:0] OP_SHRA  = 6'd22;
    localparam logic [5:0] OP_EQ    = 6'd23;
    localparam logic [5:0] OP_NE    = 6'd24;
    localparam logic [5:0] OP_LE    = 6'd25;
    localparam logic [5:0] OP_LT    = 6'd26;
    localparam logic [5:0] OP_GE    = 6'd27;
    localparam logic [5:0] OP_GT    = 6'd28;
    localparam logic [5:0] OP_LAND  = 6'd29;
    localparam logic [5:0] OP_LOR   = 6'd30;
    localparam logic [5:0] OP_PLUS  = 6'd31;
    localparam logic [5:0] OP_NEG   = 6'd32;
    localparam logic [5:0] OP_NOT   = 6'd33;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNDEF    = 2'd1;
    localparam logic [1:0] ST_NEGSHIFT = 2'd2;
    localparam logic [1:0] ST_MODZERO  = 2'd3;

    typedef struct packed {
        logic [5:0]           op;
        logic signed [DW-1:0] lhs_value;
        logic signed [DW-1:0] rhs_value;
    } t_sia_in;

    typedef struct packed {
        logic signed [DW-1:0] result;
        logic signed [DW-1:0] new_lhs;
        logic [1:0]           status;
    } t_sia_out;

    // Data carried beside the divider through every stage.
    typedef struct packed {
        logic          valid;
        logic          is_div;
        logic          is_mod;
        logic          neg_q;
        logic          neg_r;
        logic          b_zero;
        logic          asg;
        logic [1:0]    st;
        logic [DW-1:0] res;
        logic [DW-1:0] a;
    } t_side;

endpackage

[rtl/script_integer_alu_unit.sv]
// Pipelined 32-bit script ALU: one operation per cycle.
//
// An operation is taken on every edge where start is high; busy is always low.
// Its result shows on o_item with o_valid high for one cycle, in the order the
// operations came in. The receiver cannot stall: it must take each result word
// in the cycle it shows. The pipeline holds an input register, an operand stage,
// DW divider stages with one restoring subtract step each, and an output register.
// Every operation runs the full depth, so results never reorder. The unit keeps
// no state between operations.
module script_integer_alu_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sia_pkg::t_sia_in  i_item,
    output logic              o_valid,
    output sia_pkg::t_sia_out o_item
);
    import sia_pkg::*;

    // input register
    logic          r_v0;
    logic [5:0]    r_op;
    logic [DW-1:0] r_a;
    logic [DW-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
        r_op <= i_item.op;
        r_a  <= i_item.lhs_value;
        r_b  <= i_item.rhs_value;
    end

    assign busy = 1'b0;

    // operand stage: everything but the divide
    t_side         n_side;
    logic [DW-1:0] n_abs_a;
    logic [DW-1:0] n_abs_b;
    logic [DW-1:0] w_prod;
    logic          w_big;
    logic [SHW-1:0] w_sh;

    assign w_prod  = r_a * r_b;
    assign w_big   = (r_b >= DW'(DW));
    assign w_sh    = r_b[SHW-1:0];
    assign n_abs_a = r_a[DW-1] ? (~r_a + DW'(1)) : r_a;
    assign n_abs_b = r_b[DW-1] ? (~r_b + DW'(1)) : r_b;

    always_comb begin
        n_side        = '0;
        n_side.valid  = r_v0;
        n_side.a      = r_a;
        n_side.neg_q  = r_a[DW-1] ^ r_b[DW-1];
        n_side.neg_r  = r_a[DW-1];
        n_side.b_zero = (r_b == '0);
        n_side.st     = ST_OK;
        unique case (r_op) inside
            OP_COMMA:         n_side.res = r_b;
            OP_ADD, OP_ADDA:  n_side.res = r_a + r_b;
            OP_SUB, OP_SUBA:  n_side.res = r_a - r_b;
            OP_MUL, OP_MULA:  n_side.res = w_prod;
            OP_DIV, OP_DIVA:  n_side.is_div = 1'b1;
            OP_MOD, OP_MODA: begin
                n_side.is_mod = 1'b1;
                if (r_b == '0) begin
                    n_side.st = ST_MODZERO;
                end
            end
            OP_AND, OP_ANDA:  n_side.res = r_a & r_b;
            OP_OR,  OP_ORA:   n_side.res = r_a | r_b;
            OP_XOR, OP_XORA:  n_side.res = r_a ^ r_b;
            OP_SHL, OP_SHLA, OP_SAR, OP_SARA, OP_SHR, OP_SHRA: begin
                if (r_b[DW-1]) begin
                    n_side.st = ST_NEGSHIFT;
                end else if (r_op == OP_SHL || r_op == OP_SHLA) begin
                    n_side.res = w_big ? '0 : (r_a << w_sh);
                end else if (r_op == OP_SAR || r_op == OP_SARA) begin
                    n_side.res = w_big ? {DW{r_a[DW-1]}} : DW'($signed(r_a) >>> w_sh);
                end else begin
                    n_side.res = w_big ? '0 : (r_a >> w_sh);
                end
            end
            OP_EQ:   n_side.res = DW'(r_a == r_b);
            OP_NE:   n_side.res = DW'(r_a != r_b);
            OP_LE:   n_side.res = DW'($signed(r_a) <= $signed(r_b));
            OP_LT:   n_side.res = DW'($signed(r_a) <  $signed(r_b));
            OP_GE:   n_side.res = DW'($signed(r_a) >= $signed(r_b));
            OP_GT:   n_side.res = DW'($signed(r_a) >  $signed(r_b));
            OP_LAND: n_side.res = DW'((r_a != '0) && (r_b != '0));
            OP_LOR:  n_side.res = DW'((r_a != '0) || (r_b != '0));
            OP_PLUS: n_side.res = r_a;
            OP_NEG:  n_side.res = ~r_a + DW'(1);
            OP_NOT:  n_side.res = ~r_a;
            default: n_side.st = ST_UNDEF;
        endcase
        // even opcodes from 2 to 22 write back unless an error dropped them
        n_side.asg = (r_op != OP_COMMA) && (r_op <= OP_SHRA) && !r_op[0]
                     && (n_side.st == ST_OK);
    end

    // divider pipeline; entry 0 is the operand stage
    t_side         r_side [DW+1];
    logic [DW:0]   r_rem  [DW+1];
    logic [DW-1:0] r_quo  [DW+1];
    logic [DW-1:0] r_dvs  [DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0].valid <= 1'b0;
        end else begin
            r_side[0].valid <= n_side.valid;
        end
        r_side[0].is_div <= n_side.is_div;
        r_side[0].is_mod <= n_side.is_mod;
        r_side[0].neg_q  <= n_side.neg_q;
        r_side[0].neg_r  <= n_side.neg_r;
        r_side[0].b_zero <= n_side.b_zero;
        r_side[0].asg    <= n_side.asg;
        r_side[0].st     <= n_side.st;
        r_side[0].res    <= n_side.res;
        r_side[0].a      <= n_side.a;
        r_rem[0] <= '0;
        r_quo[0] <= n_abs_a;
        r_dvs[0] <= n_abs_b;
    end

    for (genvar k = 0; k < DW; k++) begin : g_div
        logic [DW:0] w_try;
        logic        w_fit;

        assign w_try = {r_rem[k][DW-1:0], r_quo[k][DW-1]};
        assign w_fit = (w_try >= {1'b0, r_dvs[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k+1].valid <= 1'b0;
            end else begin
                r_side[k+1].valid <= r_side[k].valid;
            end
            r_side[k+1].is_div <= r_side[k].is_div;
            r_side[k+1].is_mod <= r_side[k].is_mod;
            r_side[k+1].neg_q  <= r_side[k].neg_q;
            r_side[k+1].neg_r  <= r_side[k].neg_r;
            r_side[k+1].b_zero <= r_side[k].b_zero;
            r_side[k+1].asg    <= r_side[k].asg;
            r_side[k+1].st     <= r_side[k].st;
            r_side[k+1].res    <= r_side[k].res;
            r_side[k+1].a      <= r_side[k].a;
            r_rem[k+1] <= w_fit ? (w_try - {1'b0, r_dvs[k]}) : w_try;
            r_quo[k+1] <= {r_quo[k][DW-2:0], w_fit};
            r_dvs[k+1] <= r_dvs[k];
        end
    end

    // sign fixup and output register
    t_side         w_last;
    logic [DW-1:0] w_q;
    logic [DW-1:0] w_r;
    logic [DW-1:0] n_res;
    t_sia_out      r_out;
    logic          r_out_v;

    assign w_last = r_side[DW];
    assign w_q    = r_quo[DW];
    assign w_r    = r_rem[DW][DW-1:0];

    always_comb begin
        n_res = w_last.res;
        if (w_last.is_div) begin
            n_res = w_last.b_zero ? '0 : (w_last.neg_q ? (~w_q + DW'(1)) : w_q);
        end else if (w_last.is_mod) begin
            n_res = w_last.b_zero ? '0 : (w_last.neg_r ? (~w_r + DW'(1)) : w_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= w_last.valid;
        end
        r_out.result  <= n_res;
        r_out.new_lhs <= w_last.asg ? n_res : w_last.a;
        r_out.status  <= w_last.st;
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

endmodule

[rtl/sia_checker.sv]
// Port-level checks of the script ALU and their binding.
`include "assert_macros.svh"

module sia_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input sia_pkg::t_sia_in  i_item,
    input logic              o_valid,
    input sia_pkg::t_sia_out o_item
);
    import sia_pkg::*;

    localparam int WW = $clog2(LATENCY + 1);

    // count edges since reset until the pipeline holds only fresh words
    logic [WW-1:0] r_warm;
    logic          w_warm;
    logic          w_take;
    logic          w_comma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != WW'(LATENCY)) begin
            r_warm <= r_warm + WW'(1);
        end
    end

    assign w_warm  = (r_warm == WW'(LATENCY));
    assign w_take  = start && !busy;
    assign w_comma = (i_item.op == OP_COMMA);

    property p_latency;
        w_warm |-> (o_valid == $past(w_take, LATENCY));
    endproperty

    property p_comma;
        (w_warm && o_valid && $past(w_comma, LATENCY))
            |-> (o_item.result == $past(i_item.rhs_value, LATENCY));
    endproperty

    `SIA_NEVER(a_never_busy, i_clk, i_rst_n, busy)
    `SIA_ASSERT(a_fixed_latency, i_clk, i_rst_n, p_latency)
    `SIA_ASSERT(a_comma_passes, i_clk, i_rst_n, p_comma)
    `SIA_NEVER(a_error_zero, i_clk, i_rst_n, o_valid && o_item.status != ST_OK && o_item.result != '0)

endmodule

bind script_integer_alu_unit sia_checker u_sia_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_item  (i_item),
    .o_valid (o_valid),
    .o_item  (o_item)
);

[sim/tb_script_integer_alu_unit.sv]
// Testbench for the script integer ALU: directed table plus random words, checked by a predictor.
`timescale 1ns / 1ps

module tb_script_integer_alu_unit;
    import sia_pkg::*;

    localparam int WATCHDOG = 5000;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_sia_in  i_item;
    logic     o_valid;
    t_sia_out o_item;

    t_sia_out expected_q[$];
    int       n_errors;
    int       n_words;
    int       n_results;
    int       idle_cycles;
    bit       sender_done;

    typedef struct {
        t_sia_in  stim;
        bit       fixed;
        t_sia_out want;
    } t_row;

    script_integer_alu_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_sia_out alu_predict(t_sia_in w);
        t_sia_out        r;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
        logic [DW-1:0]   qa;
        logic [DW-1:0]   qb;
        logic [DW-1:0]   q;
        logic            asg;
        a   = w.lhs_value;
        b   = w.rhs_value;
        r.result  = '0;
        r.status  = ST_OK;
        asg = (w.op <= OP_SHRA) && (w.op != OP_COMMA) && !w.op[0];
        qa  = a[DW-1] ? -a : a;
        qb  = b[DW-1] ? -b : b;
        case (w.op)
            OP_COMMA:         r.result = b;
            OP_ADD, OP_ADDA:  r.result = a + b;
            OP_SUB, OP_SUBA:  r.result = a - b;
            OP_MUL, OP_MULA:  r.result = a * b;
            OP_DIV, OP_DIVA: begin
                if (b != 0) begin
                    q = qa / qb;
                    r.result = (a[DW-1] != b[DW-1]) ? -q : q;
                end
            end
            OP_MOD, OP_MODA: begin
                if (b == 0) begin
                    r.status = ST_MODZERO;
                    asg = 1'b0;
                end else begin
                    q = qa % qb;
                    r.result = a[DW-1] ? -q : q;
                end
            end
            OP_AND, OP_ANDA:  r.result = a & b;
            OP_OR, OP_ORA:    r.result = a | b;
            OP_XOR, OP_XORA:  r.result = a ^ b;
            OP_SHL, OP_SHLA, OP_SAR, OP_SARA, OP_SHR, OP_SHRA: begin
                if (b[DW-1]) begin
                    r.status = ST_NEGSHIFT;
                    asg = 1'b0;
                end else if (w.op <= OP_SHLA) begin
                    r.result = (b >= DW) ? '0 : a << b;
                end else if (w.op <= OP_SARA) begin
                    r.result = (b >= DW) ? {DW{a[DW-1]}} : DW'($signed(a) >>> b);
                end else begin
                    r.result = (b >= DW) ? '0 : a >> b;
                end
            end
            OP_EQ:   r.result = DW'(a == b);
            OP_NE:   r.result = DW'(a != b);
            OP_LE:   r.result = DW'($signed(a) <= $signed(b));
            OP_LT:   r.result = DW'($signed(a) < $signed(b));
            OP_GE:   r.result = DW'($signed(a) >= $signed(b));
            OP_GT:   r.result = DW'($signed(a) > $signed(b));
            OP_LAND: r.result = DW'((a != 0) && (b != 0));
            OP_LOR:  r.result = DW'((a != 0) || (b != 0));
            OP_PLUS: r.result = a;
            OP_NEG:  r.result = -a;
            OP_NOT:  r.result = ~a;
            default: r.status = ST_UNDEF;
        endcase
        r.new_lhs = asg ? r.result : a;
        return r;
    endfunction

    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            4:       return $urandom_range(0, 40);
            5:       return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_sia_in pick_word();
        t_sia_in w;
        w.op        = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(34, 63))
                                                  : 6'($urandom_range(0, 33));
        w.lhs_value = pick_operand();
        w.rhs_value = pick_operand();
        if (w.op >= OP_SHL && w.op <= OP_SHRA && $urandom_range(0, 3) != 0)
            w.rhs_value = $urandom_range(0, 40);
        return w;
    endfunction

    // Hold start high for one accepted word; optionally leave a gap after it.
    task automatic send_word(t_sia_in w, bit gaps);
        int gap;
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        expected_q.push_back(alu_predict(w));
        n_words++;
        if (gaps) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                               : $urandom_range(0, 3);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Check each result word against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result word %h", o_item);
                n_errors++;
            end else begin
                t_sia_out e;
                e = expected_q.pop_front();
                n_results++;
                if (o_item.result !== e.result) begin
                    $error("result: expected %h actual %h", e.result, o_item.result);
                    n_errors++;
                end
                if (o_item.new_lhs !== e.new_lhs) begin
                    $error("new_lhs: expected %h actual %h", e.new_lhs, o_item.new_lhs);
                    n_errors++;
                end
                if (o_item.status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_item.status);
                    n_errors++;
                end
            end
        end
    end

    // Count cycles with no word moving in either direction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else if (i_rst_n && !(sender_done && expected_q.size() == 0))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL script_integer_alu_unit");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        int   k;
        idle_cycles = 0;
        n_errors    = 0;
        n_words     = 0;
        n_results   = 0;
        sender_done = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;

        // Directed words: fixed expectations where obvious, else predicted.
        rows.push_back('{'{OP_ADD, 32'h7fff_ffff, 32'h1}, 1,
                         '{32'h8000_0000, 32'h7fff_ffff, ST_OK}});
        rows.push_back('{'{OP_DIV, 32'h5, 32'h0}, 1, '{32'h0, 32'h5, ST_OK}});
        rows.push_back('{'{OP_DIVA, 32'h5, 32'h0}, 1, '{32'h0, 32'h0, ST_OK}});
        rows.push_back('{'{OP_DIV, 32'h8000_0000, 32'hffff_ffff}, 1,
                         '{32'h8000_0000, 32'h8000_0000, ST_OK}});
        rows.push_back('{'{OP_MODA, 32'h7, 32'h0}, 1, '{32'h0, 32'h7, ST_MODZERO}});
        rows.push_back('{'{OP_SHLA, 32'h3, 32'hffff_ffff}, 1,
                         '{32'h0, 32'h3, ST_NEGSHIFT}});
        rows.push_back('{'{OP_SAR, 32'h8000_0000, 32'd40}, 1,
                         '{32'hffff_ffff, 32'h8000_0000, ST_OK}});
        rows.push_back('{'{OP_SHL, 32'h1, 32'd32}, 1, '{32'h0, 32'h1, ST_OK}});
        rows.push_back('{'{OP_SHR, 32'hffff_ffff, 32'd32}, 1,
                         '{32'h0, 32'hffff_ffff, ST_OK}});
        rows.push_back('{'{6'd63, 32'h1234, 32'h1}, 1, '{32'h0, 32'h1234, ST_UNDEF}});
        rows.push_back('{'{6'd34, 32'h0, 32'h0}, 1, '{32'h0, 32'h0, ST_UNDEF}});
        rows.push_back('{'{OP_DIV, -32'sd7, 32'sd2}, 0, '{default: '0}});
        rows.push_back('{'{OP_MOD, -32'sd7, 32'sd2}, 0, '{default: '0}});
        rows.push_back('{'{OP_MOD, 32'sd7, -32'sd2}, 0, '{default: '0}});
        rows.push_back('{'{OP_MULA, 32'h7fff_ffff, 32'h7fff_ffff}, 0, '{default: '0}});
        rows.push_back('{'{OP_SARA, 32'h8000_0010, 32'd4}, 0, '{default: '0}});
        rows.push_back('{'{OP_SHRA, 32'h8000_0010, 32'd31}, 0, '{default: '0}});
        rows.push_back('{'{OP_LT, 32'h8000_0000, 32'h7fff_ffff}, 0, '{default: '0}});
        rows.push_back('{'{OP_GE, 32'h8000_0000, 32'h7fff_ffff}, 0, '{default: '0}});
        rows.push_back('{'{OP_LAND, 32'h0, 32'hffff_ffff}, 0, '{default: '0}});
        rows.push_back('{'{OP_NEG, 32'h8000_0000, 32'h0}, 0, '{default: '0}});
        rows.push_back('{'{OP_NOT, 32'h0, 32'hffff_ffff}, 0, '{default: '0}});
        rows.push_back('{'{OP_COMMA, 32'h1, 32'h8000_0000}, 0, '{default: '0}});
        // Sweep every defined opcode once on mixed operands.
        for (k = 0; k <= 33; k++) begin
            row.stim  = '{k[5:0], 32'hf0f0_1234, 32'h0000_0005};
            row.fixed = 1'b0;
            rows.push_back(row);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            send_word(rows[r].stim, 1'b0);
            if (rows[r].fixed && expected_q[$] != rows[r].want) begin
                $error("directed row %0d: table %h predictor %h", r,
                       rows[r].want, expected_q[$]);
                n_errors++;
            end
        end

        // Back-to-back burst, then drain the pipe completely.
        for (k = 0; k < 100; k++) send_word(pick_word(), 1'b0);
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);

        for (k = 0; k < 700; k++) send_word(pick_word(), k >= 300);
        start <= 1'b0;
        sender_done = 1'b1;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("Ran %0d words over all opcodes, edge operands and error codes;", n_words);
        $display("%0d results checked, bursts and random gaps included.", n_results);
        if (n_errors == 0)
            $display("PASS script_integer_alu_unit");
        else
            $display("FAIL script_integer_alu_unit");
        $finish;
    end

endmodule
